// ----- rtl/core/ptsch_pkg.sv -----
// ----------------------------------------------------------------------------
// ptsch_pkg
// Shared codes and widths for the periodic timer scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptsch_pkg;

  // request opcodes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_CANCEL = 3'd2;
  localparam logic [2:0] OP_QUERY  = 3'd3;
  localparam logic [2:0] OP_STOP   = 3'd4;

  // result codes
  localparam logic [2:0] EV_FIRED       = 3'd0;
  localparam logic [2:0] EV_ADDED       = 3'd1;
  localparam logic [2:0] EV_REJ_ARMED   = 3'd2;
  localparam logic [2:0] EV_REJ_STOPPED = 3'd3;
  localparam logic [2:0] EV_CANCELLED   = 3'd4;
  localparam logic [2:0] EV_NOT_FOUND   = 3'd5;
  localparam logic [2:0] EV_QUERY       = 3'd6;
  localparam logic [2:0] EV_STOPPED     = 3'd7;

  // most firings reported for one tick
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // fixed field widths
  localparam int ID_W  = 4;
  localparam int PER_W = 24;

  typedef logic [2:0] code_t;

endpackage

// ----- rtl/core/ptsch_ram.sv -----
// ----------------------------------------------------------------------------
// ptsch_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/periodic_timer_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_scheduler_core
// Timer slot table: add/cancel/query/stop requests and ticks that fire due
// slots in due-time order, re-arming periodic slots.
//
//   channel  dir  tdata                                   tuser       tlast
//   s_axis   in   task_id,delay,period,resched,fixed_rate opcode      -
//   m_axis   out  slot_out,answer                         event_res   last
//
// Add, cancel, query and stop go via the response state to the output register
// under output backpressure. A tick scans once per fired slot, plus a final scan
// unless the firing limit is hit; each scan reads every slot's due time through
// the single RAM read port. Reset clears time, armed bits and halt; the slot RAM
// needs no clearing. A new request is taken only when the previous one has fully
// finished; a stalled result beat holds the sequencer in place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_timer_scheduler_core #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // task_id, delay, period, reschedule, fixed_rate
  input  logic [2:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // slot_out, answer
  output logic [2:0]  m_axis_tuser,  // event_res
  output logic        m_axis_tlast   // last
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = SW + 1;
  localparam int TB = TIME_BITS;
  localparam int DW = TB + ptsch_pkg::PER_W + 1;
  localparam logic [TB-1:0] THALF = {1'b1, {(TB-1){1'b0}}};
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_FLUSH  = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  // input fields
  logic [2:0]                  op;
  logic [ptsch_pkg::ID_W-1:0]  id;
  logic [ptsch_pkg::PER_W-1:0] in_delay;
  logic [ptsch_pkg::PER_W-1:0] in_period;
  logic                        in_resched;
  logic                        in_frate;

  assign op         = s_axis_tuser;
  assign id         = s_axis_tdata[3:0];
  assign in_delay   = s_axis_tdata[27:4];
  assign in_period  = s_axis_tdata[51:28];
  assign in_resched = s_axis_tdata[52];
  assign in_frate   = s_axis_tdata[53];

  // control state
  logic [2:0]                  state;
  logic [TB-1:0]               time_now;
  logic [SLOTS-1:0]            armed;
  logic [SLOTS-1:0]            done;
  logic                        halted;
  logic [CW-1:0]               scan_idx;
  logic                        rd_vld;
  logic [SW-1:0]               rd_slot;
  logic                        found;
  logic                        have_pend;
  logic [ptsch_pkg::CNT_W-1:0] cnt;

  // best candidate of the current scan
  logic [SW-1:0]               best_slot;
  logic [TB-1:0]               best_key;
  logic [TB-1:0]               best_due;
  logic [ptsch_pkg::PER_W-1:0] best_per;
  logic                        best_rate;
  logic [SW-1:0]               pend_slot;

  // single-result response
  logic [ptsch_pkg::ID_W-1:0] resp_slot;
  ptsch_pkg::code_t           resp_ev;
  logic                       resp_ans;

  // output register
  logic                       m_valid;
  logic [ptsch_pkg::ID_W-1:0] m_slot;
  ptsch_pkg::code_t           m_ev;
  logic                       m_ans;
  logic                       m_last;

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {3'b000, m_ans, m_slot};
  assign m_axis_tuser  = m_ev;
  assign m_axis_tlast  = m_last;

  logic accept, can_emit, proceed, out_load;
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign can_emit      = !m_valid || m_axis_tready;
  assign proceed       = !have_pend || can_emit;

  // a result beat enters the output register this cycle
  assign out_load = ((state == ST_DECIDE) && proceed && have_pend) ||
                    (((state == ST_FLUSH) || (state == ST_RESP)) && can_emit);

  // request slot decode
  logic [SW-1:0] id_idx;
  logic          id_ok;
  logic          add_ok;
  assign id_idx = SW'(id);
  assign id_ok  = (9'(id) < 9'(SLOTS));
  assign add_ok = !halted && id_ok && (!armed[id_idx] || in_resched);

  // slot RAM: {rate mode, period, due}
  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [DW-1:0] ram_rdata;

  ptsch_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx[SW-1:0]),
    .rdata (ram_rdata)
  );

  // scan evaluation of the slot read last cycle
  logic [TB-1:0]               rd_due;
  logic [ptsch_pkg::PER_W-1:0] rd_per;
  logic                        rd_rate;
  logic [TB-1:0]               rd_key;
  logic                        cand;
  assign rd_due  = ram_rdata[TB-1:0];
  assign rd_per  = ram_rdata[TB+ptsch_pkg::PER_W-1:TB];
  assign rd_rate = ram_rdata[DW-1];
  assign rd_key  = rd_due - time_now + THALF;
  assign cand    = rd_vld && armed[rd_slot] && !done[rd_slot] && (rd_key <= THALF)
                   && (!found || rd_key < best_key);

  // RAM write: new slot on add, re-arm on firing
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = id_idx;
    ram_wdata = {in_frate, in_period, time_now + TB'(in_delay)};
    if (state == ST_IDLE) begin
      ram_we = accept && (op == ptsch_pkg::OP_ADD) && add_ok;
    end else if (state == ST_DECIDE) begin
      ram_we    = proceed && found && (best_per != '0);
      ram_waddr = best_slot;
      ram_wdata = {best_rate, best_per,
                   (best_rate ? best_due : time_now) + TB'(best_per)};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      time_now  <= '0;
      armed     <= '0;
      done      <= '0;
      halted    <= 1'b0;
      scan_idx  <= '0;
      rd_vld    <= 1'b0;
      found     <= 1'b0;
      have_pend <= 1'b0;
      cnt       <= '0;
      m_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_valid && m_axis_tready) begin
        m_valid <= 1'b0;
      end
      rd_vld  <= (state == ST_SCAN) && (scan_idx < SLOTS_C);
      rd_slot <= scan_idx[SW-1:0];
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            resp_slot <= (op == ptsch_pkg::OP_STOP) ? '0 : id;
            resp_ans  <= (op == ptsch_pkg::OP_QUERY) && id_ok && !halted && armed[id_idx];
            unique case (op)
              ptsch_pkg::OP_TICK: begin
                time_now  <= time_now + 1'b1;
                done      <= '0;
                cnt       <= '0;
                have_pend <= 1'b0;
                scan_idx  <= '0;
                found     <= 1'b0;
                state     <= ST_SCAN;
              end
              ptsch_pkg::OP_ADD: begin
                if (halted) begin
                  resp_ev <= ptsch_pkg::EV_REJ_STOPPED;
                end else if (!id_ok) begin
                  resp_ev <= ptsch_pkg::EV_NOT_FOUND;
                end else if (!add_ok) begin
                  resp_ev <= ptsch_pkg::EV_REJ_ARMED;
                end else begin
                  resp_ev        <= ptsch_pkg::EV_ADDED;
                  armed[id_idx]  <= 1'b1;
                end
                state <= ST_RESP;
              end
              ptsch_pkg::OP_CANCEL: begin
                if (!halted && id_ok && armed[id_idx]) begin
                  armed[id_idx] <= 1'b0;
                  resp_ev       <= ptsch_pkg::EV_CANCELLED;
                end else begin
                  resp_ev <= ptsch_pkg::EV_NOT_FOUND;
                end
                state <= ST_RESP;
              end
              ptsch_pkg::OP_QUERY: begin
                if (id_ok) begin
                  resp_ev <= ptsch_pkg::EV_QUERY;
                end else begin
                  resp_ev <= ptsch_pkg::EV_NOT_FOUND;
                end
                state <= ST_RESP;
              end
              ptsch_pkg::OP_STOP: begin
                armed     <= '0;
                halted    <= 1'b1;
                resp_ev   <= ptsch_pkg::EV_STOPPED;
                state     <= ST_RESP;
              end
              default: ;
            endcase
          end
        end
        // one pass over all slots, keeping the earliest due one
        ST_SCAN: begin
          if (scan_idx < SLOTS_C) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (cand) begin
            found     <= 1'b1;
            best_slot <= rd_slot;
            best_key  <= rd_key;
            best_due  <= rd_due;
            best_per  <= rd_per;
            best_rate <= rd_rate;
          end
          if (scan_idx == SLOTS_C && !rd_vld) begin
            state <= ST_DECIDE;
          end
        end
        // report the previous firing, take the new one
        ST_DECIDE: begin
          if (proceed) begin
            if (have_pend) begin
              m_slot  <= ptsch_pkg::ID_W'(pend_slot);
              m_ev    <= ptsch_pkg::EV_FIRED;
              m_ans   <= 1'b0;
              m_last  <= !found;
            end
            if (found) begin
              pend_slot       <= best_slot;
              have_pend       <= 1'b1;
              done[best_slot] <= 1'b1;
              if (best_per == '0) begin
                armed[best_slot] <= 1'b0;
              end
              cnt <= cnt + 1'b1;
              if (cnt == ptsch_pkg::CNT_W'(ptsch_pkg::MAX_RESULTS - 1)) begin
                state <= ST_FLUSH;
              end else begin
                scan_idx <= '0;
                found    <= 1'b0;
                state    <= ST_SCAN;
              end
            end else begin
              have_pend <= 1'b0;
              state     <= ST_IDLE;
            end
          end
        end
        ST_FLUSH: begin
          if (can_emit) begin
            m_slot    <= ptsch_pkg::ID_W'(pend_slot);
            m_ev      <= ptsch_pkg::EV_FIRED;
            m_ans     <= 1'b0;
            m_last    <= 1'b1;
            have_pend <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        ST_RESP: begin
          if (can_emit) begin
            m_slot  <= resp_slot;
            m_ev    <= resp_ev;
            m_ans   <= resp_ans;
            m_last  <= 1'b1;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= ptsch_pkg::CNT_W'(ptsch_pkg::MAX_RESULTS))
    else $error("firing count beyond limit");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> state == ST_SCAN)
    else $error("scan read outside scan");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    accept && op == ptsch_pkg::OP_STOP |=> armed == '0 && halted)
    else $error("stop left a slot armed");

  a_fire_armed: assert property (@(posedge clk) disable iff (rst)
    state == ST_DECIDE && found |-> armed[best_slot] && !done[best_slot])
    else $error("firing an unarmed or finished slot");

endmodule
